// ===== hdl/text_console_writer_assert.svh =====
// assertion helpers shared by the console modules
// both expect signals named clock and reset in the enclosing module
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// condition holds in the same cycle
`define TCW_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int CURSOR_W = 11;

   typedef enum logic [2:0] {
      OP_PUT    = 3'd0,
      OP_ATTR   = 3'd1,
      OP_CURSOR = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] DEFAULT_ATTR = 8'h07;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] char_code;
      logic [7:0] color;
      logic [6:0] column;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor;
      logic                scrolled;
      logic [7:0]          cell_char;
      logic [7:0]          cell_color;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic set_attr;
      logic set_cursor;
      logic home;
      logic newline_step;
      logic return_step;
      logic back_step;
      logic put_step;
      logic cnt_one;
      logic cnt_tab;
      logic rem_load;
      logic rem_step;
      logic addr_clear;
      logic copy_step;
      logic fill_step;
      logic fill_default;
      logic scroll_done;
      logic read_issue;
      logic load_rsp;
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [2:0] op;
      logic       is_newline;
      logic       is_return;
      logic       is_backspace;
      logic       is_tab;
      logic       at_end;
      logic       nl_scroll;
      logic       cursor_nz;
      logic       rem_ge_tab;
      logic       cnt_last;
      logic       copy_last;
      logic       fill_last;
   } ctl_sts_type;

endpackage

// ===== hdl/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tcw_datapath.sv =====
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module tcw_datapath #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_pkg::req_type     req_data,
   input  tcw_pkg::ctl_cmd_type cmd,
   output tcw_pkg::ctl_sts_type sts,
   output tcw_pkg::rsp_type     rsp_data
);

   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int XW    = $clog2(COLUMNS);
   localparam int TW    = $clog2(TAB_WIDTH + 1);

   req_type        q_ff, q_in;
   rsp_type        rsp_ff, rsp_in;
   logic [7:0]     attr_ff, attr_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [XW-1:0]  col_ff, col_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [AW-1:0]  waddr_ff, waddr_in;
   logic           pend_ff, pend_in;
   logic [XW-1:0]  rem_ff, rem_in;
   logic [TW-1:0]  cnt_ff, cnt_in;
   logic           scrolled_ff, scrolled_in;

   logic [CW-1:0]  lin;
   logic [CW-1:0]  lin_prev;
   logic [XW-1:0]  sat_col;
   logic [RW-1:0]  sat_row;
   logic [AW-1:0]  cell_addr;
   logic [7:0]     put_char;

   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [15:0]    mem_wd;
   logic           mem_re;
   logic [AW-1:0]  mem_ra;
   logic [15:0]    mem_rd;

   assign lin      = CW'(row_ff) * CW'(COLUMNS) + CW'(col_ff);
   assign lin_prev = lin - CW'(1);
   assign put_char = (q_ff.char_code == CH_TAB) ? BLANK_CHAR : q_ff.char_code;

   // out-of-range column and row saturate
   always_comb begin
      if (32'(q_ff.column) >= COLUMNS) begin
         sat_col = XW'(COLUMNS - 1);
      end else begin
         sat_col = XW'(q_ff.column);
      end
      if (32'(q_ff.row) >= ROWS) begin
         sat_row = RW'(ROWS - 1);
      end else begin
         sat_row = RW'(q_ff.row);
      end
   end

   assign cell_addr = AW'(sat_row) * AW'(COLUMNS) + AW'(sat_col);

   // write port: pending copy beats everything, only one source is active otherwise
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = {attr_ff, BLANK_CHAR};
      if (pend_ff) begin
         mem_we = 1'b1;
         mem_wa = waddr_ff;
         mem_wd = mem_rd;
      end else if (cmd.fill_step) begin
         mem_we = 1'b1;
         mem_wa = addr_ff;
         mem_wd = cmd.fill_default ? {DEFAULT_ATTR, BLANK_CHAR} : {attr_ff, BLANK_CHAR};
      end else if (cmd.put_step) begin
         mem_we = 1'b1;
         mem_wa = lin[AW-1:0];
         mem_wd = {attr_ff, put_char};
      end else if (cmd.back_step) begin
         mem_we = 1'b1;
         mem_wa = lin_prev[AW-1:0];
         mem_wd = {attr_ff, BLANK_CHAR};
      end
   end

   assign mem_re = cmd.copy_step | cmd.read_issue;
   assign mem_ra = cmd.copy_step ? (addr_ff + AW'(COLUMNS)) : cell_addr;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   always_comb begin
      q_in        = cmd.capture ? req_data : q_ff;
      attr_in     = cmd.set_attr ? q_ff.color : attr_ff;
      scrolled_in = scrolled_ff;
      if (cmd.capture) begin
         scrolled_in = 1'b0;
      end else if (cmd.scroll_done) begin
         scrolled_in = 1'b1;
      end

      row_in = row_ff;
      col_in = col_ff;
      if (cmd.set_cursor) begin
         row_in = sat_row;
         col_in = sat_col;
      end else if (cmd.home) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.newline_step) begin
         row_in = row_ff + RW'(1);
         col_in = '0;
      end else if (cmd.return_step) begin
         col_in = '0;
      end else if (cmd.back_step) begin
         if (col_ff != '0) begin
            col_in = col_ff - XW'(1);
         end else begin
            row_in = row_ff - RW'(1);
            col_in = XW'(COLUMNS - 1);
         end
      end else if (cmd.put_step) begin
         if (col_ff == XW'(COLUMNS - 1)) begin
            row_in = row_ff + RW'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + XW'(1);
         end
      end else if (cmd.scroll_done) begin
         row_in = RW'(ROWS - 1);
         col_in = '0;
      end

      addr_in = addr_ff;
      if (cmd.addr_clear) begin
         addr_in = '0;
      end else if (cmd.copy_step || cmd.fill_step) begin
         addr_in = addr_ff + AW'(1);
      end
      pend_in  = cmd.copy_step;
      waddr_in = addr_ff;

      // column mod tab width by repeated subtraction
      rem_in = rem_ff;
      if (cmd.rem_load) begin
         rem_in = col_ff;
      end else if (cmd.rem_step) begin
         rem_in = rem_ff - XW'(TAB_WIDTH);
      end

      cnt_in = cnt_ff;
      if (cmd.cnt_one) begin
         cnt_in = TW'(1);
      end else if (cmd.cnt_tab) begin
         cnt_in = TW'(TAB_WIDTH) - TW'(rem_ff);
      end else if (cmd.put_step) begin
         cnt_in = cnt_ff - TW'(1);
      end

      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.cursor   = CURSOR_W'(lin);
         rsp_in.scrolled = scrolled_ff;
         if (q_ff.op == OP_READ) begin
            rsp_in.cell_char  = mem_rd[7:0];
            rsp_in.cell_color = mem_rd[15:8];
         end else begin
            rsp_in.cell_char  = '0;
            rsp_in.cell_color = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= DEFAULT_ATTR;
         row_ff  <= '0;
         col_ff  <= '0;
         addr_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         attr_ff <= attr_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         addr_ff <= addr_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      rsp_ff      <= rsp_in;
      waddr_ff    <= waddr_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      scrolled_ff <= scrolled_in;
   end

   always_comb begin
      sts              = '0;
      sts.op           = q_ff.op;
      sts.is_newline   = (q_ff.char_code == CH_NEWLINE);
      sts.is_return    = (q_ff.char_code == CH_RETURN);
      sts.is_backspace = (q_ff.char_code == CH_BACKSPACE);
      sts.is_tab       = (q_ff.char_code == CH_TAB);
      sts.at_end       = (row_ff == RW'(ROWS));
      sts.nl_scroll    = (32'(row_ff) + 1 >= ROWS);
      sts.cursor_nz    = (lin != '0);
      sts.rem_ge_tab   = (32'(rem_ff) >= TAB_WIDTH);
      sts.cnt_last     = (cnt_ff == TW'(1));
      sts.copy_last    = (addr_ff == AW'(CELLS - COLUMNS - 1));
      sts.fill_last    = (addr_ff == AW'(CELLS - 1));
   end

   assign rsp_data = rsp_ff;

   `TCW_ASSERT_SAME(a_end_at_col0, row_ff == RW'(ROWS), col_ff == '0,
      "cursor past last row with nonzero column")
   `TCW_ASSERT_SAME(a_put_in_range, cmd.put_step, row_ff < RW'(ROWS),
      "character written past last cell")
   `TCW_ASSERT_NEXT(a_copy_writes, cmd.copy_step, mem_we && mem_wa == $past(addr_ff),
      "scroll copy lost its write")

endmodule

// ===== hdl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module tcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcw_pkg::ctl_cmd_type cmd,
   input  tcw_pkg::ctl_sts_type sts
);

   import tcw_pkg::*;

   typedef enum logic [9:0] {
      S_INIT   = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_DECODE = 10'b0000000100,
      S_MOD    = 10'b0000001000,
      S_PUT    = 10'b0000010000,
      S_COPY   = 10'b0000100000,
      S_DRAIN  = 10'b0001000000,
      S_FILL   = 10'b0010000000,
      S_CLEAR  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            // power-up sweep fills the screen with the reset attribute
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.op)
               OP_PUT: begin
                  if (sts.is_newline) begin
                     if (sts.nl_scroll) begin
                        cmd.addr_clear = 1'b1;
                        state_in       = S_COPY;
                     end else begin
                        cmd.newline_step = 1'b1;
                        state_in         = S_DONE;
                     end
                  end else if (sts.is_return) begin
                     cmd.return_step = 1'b1;
                     state_in        = S_DONE;
                  end else if (sts.is_backspace) begin
                     cmd.back_step = sts.cursor_nz;
                     state_in      = S_DONE;
                  end else if (sts.is_tab) begin
                     cmd.rem_load = 1'b1;
                     state_in     = S_MOD;
                  end else begin
                     cmd.cnt_one = 1'b1;
                     state_in    = S_PUT;
                  end
               end
               OP_ATTR: begin
                  cmd.set_attr = 1'b1;
                  state_in     = S_DONE;
               end
               OP_CURSOR: begin
                  cmd.set_cursor = 1'b1;
                  state_in       = S_DONE;
               end
               OP_CLEAR: begin
                  cmd.addr_clear = 1'b1;
                  state_in       = S_CLEAR;
               end
               OP_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MOD: begin
            if (sts.rem_ge_tab) begin
               cmd.rem_step = 1'b1;
            end else begin
               cmd.cnt_tab = 1'b1;
               state_in    = S_PUT;
            end
         end
         S_PUT: begin
            // past the last cell the screen scrolls before the write
            if (sts.at_end) begin
               cmd.addr_clear = 1'b1;
               state_in       = S_COPY;
            end else begin
               cmd.put_step = 1'b1;
               if (sts.cnt_last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (sts.copy_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FILL;
         end
         S_FILL: begin
            cmd.fill_step    = 1'b1;
            cmd.fill_default = 1'b1;
            if (sts.fill_last) begin
               cmd.scroll_done = 1'b1;
               state_in        = sts.is_newline ? S_DONE : S_PUT;
            end
         end
         S_CLEAR: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               cmd.home = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TCW_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state_ff == S_DECODE,
      "accepted item not decoded")
   `TCW_ASSERT_NEXT(a_done_loads, state_ff == S_DONE && (!rsp_valid_ff || rsp_ready),
      rsp_valid_ff && state_ff == S_IDLE, "finished item not presented")
   `TCW_ASSERT_NEXT(a_scroll_resumes, state_ff == S_FILL && sts.fill_last && !sts.is_newline,
      state_ff == S_PUT, "scroll did not resume the pending write")

endmodule

// ===== hdl/text_console_writer.sv =====
// Text console: a COLUMNS x ROWS screen of 16-bit cells (attribute in the high
// byte, character in the low byte), a linear cursor and a current attribute.
// Input channel req_valid/req_ready/req_data carries one operation per item:
// put character, set attribute, set cursor, clear screen or read cell.
// Output channel rsp_valid/rsp_ready/rsp_data returns exactly one item per
// input: cursor after the operation, scroll flag and the read cell.
// Attribute, cursor, read, return, backspace and a newline that does not scroll
// finish straight from decode; a printable character is written in S_PUT, and a
// tab first reduces the column mod TAB_WIDTH in S_MOD, then writes its spaces.
// Each scroll is a one-cell-per-cycle copy through the single write port of the
// screen memory, then the blank bottom row; a put that finds the cursor past
// the end scrolls first and then resumes the write. A clear sweeps the whole
// screen and then homes the cursor.
// Items are handled one at a time; a new item is taken while the previous
// result still waits in the output register, and a stalled receiver only
// holds the next item at its final step.
// After reset the block sweeps the screen to blanks of attribute 0x07 with
// req_ready low.
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_data
);

   import tcw_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcw_datapath #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
